### rtl/core/dense_shortest_path_tree_defines.svh
// Assertion shorthands for the shortest path tree block.
// All properties sample on the rising edge of clk and are off while arst_n is low.
`ifndef DENSE_SHORTEST_PATH_TREE_DEFINES_SVH
`define DENSE_SHORTEST_PATH_TREE_DEFINES_SVH

// same-cycle implication
`define DSPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/dspt_pkg.sv
`default_nettype none

package dspt_pkg;

	localparam int MAX_NODES   = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int LEN_BITS    = 24;
	localparam int NODE_BITS   = 5;
	localparam int NE_BITS     = 16;
	localparam int VBITS       = $clog2(MAX_NODES);
	localparam int CNT_BITS    = VBITS + 1;
	localparam int ADDR_BITS   = 2 * VBITS;
	localparam int MAT_DEPTH   = MAX_NODES * MAX_NODES;
	localparam int SUM_BITS    = ((LEN_BITS > WEIGHT_BITS) ? LEN_BITS : WEIGHT_BITS) + 1;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_COUNT = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NO_EDGE    = 1'd1;

	localparam logic [NODE_BITS-1:0] NODE_COUNT_RST = 5'd5;
	localparam logic [NE_BITS-1:0]   NO_EDGE_RST    = 16'd999;

	localparam logic [SUM_BITS-1:0] LEN_MAX =
		{{(SUM_BITS - LEN_BITS){1'b0}}, {LEN_BITS{1'b1}}};

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE     = 3'd0;
	localparam step_t STEP_INIT_SET = 3'd1;
	localparam step_t STEP_INIT_RD  = 3'd2;
	localparam step_t STEP_SCAN_SET = 3'd3;
	localparam step_t STEP_SCAN     = 3'd4;
	localparam step_t STEP_EMIT     = 3'd5;
	localparam step_t STEP_RELAX    = 3'd6;

	typedef logic [1:0] cond_t;

	localparam cond_t COND_NEVER   = 2'd0;
	localparam cond_t COND_START   = 2'd1;
	localparam cond_t COND_VLAST   = 2'd2;
	localparam cond_t COND_LASTRND = 2'd3;

	typedef struct packed {
		logic  clr_run;
		logic  v_one;
		logic  v_inc;
		logic  init_rd;
		logic  relax_rd;
		logic  scan_clr;
		logic  scan_en;
		logic  emit;
		cond_t cond;
		step_t tgt;
		step_t nxt;
	} ucw_t;

	// control store: jump to tgt when cond holds, else go to nxt
	function automatic ucw_t ucode(input step_t s);
		ucw_t w;
		w = '0;
		case (s)
			STEP_IDLE: begin
				w.cond = COND_START;
				w.tgt  = STEP_INIT_SET;
				w.nxt  = STEP_IDLE;
			end
			STEP_INIT_SET: begin
				w.clr_run = 1'b1;
				w.v_one   = 1'b1;
				w.cond    = COND_NEVER;
				w.nxt     = STEP_INIT_RD;
			end
			STEP_INIT_RD: begin
				w.init_rd = 1'b1;
				w.v_inc   = 1'b1;
				w.cond    = COND_VLAST;
				w.tgt     = STEP_SCAN_SET;
				w.nxt     = STEP_INIT_RD;
			end
			STEP_SCAN_SET: begin
				w.v_one    = 1'b1;
				w.scan_clr = 1'b1;
				w.cond     = COND_NEVER;
				w.nxt      = STEP_SCAN;
			end
			STEP_SCAN: begin
				w.scan_en = 1'b1;
				w.v_inc   = 1'b1;
				w.cond    = COND_VLAST;
				w.tgt     = STEP_EMIT;
				w.nxt     = STEP_SCAN;
			end
			STEP_EMIT: begin
				w.emit  = 1'b1;
				w.v_one = 1'b1;
				w.cond  = COND_LASTRND;
				w.tgt   = STEP_IDLE;
				w.nxt   = STEP_RELAX;
			end
			STEP_RELAX: begin
				w.relax_rd = 1'b1;
				w.v_inc    = 1'b1;
				w.cond     = COND_VLAST;
				w.tgt      = STEP_SCAN_SET;
				w.nxt      = STEP_RELAX;
			end
			default: begin
				w.nxt = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	function automatic logic [LEN_BITS-1:0] sat_len(input logic [SUM_BITS-1:0] s);
		logic [LEN_BITS-1:0] r;
		if (s > LEN_MAX)
			r = '1;
		else
			r = s[LEN_BITS-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/dspt_ram.sv
`default_nettype none

module dspt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/dense_shortest_path_tree.sv
// Shortest path tree over a dense weighted digraph. Matrix entries load one per
// transaction (start high while busy low), one per clock. An entry with start_req set
// also starts a run from vertex 1: busy rises and the block emits node_count-1 tree
// edges (node_count clamped to 2..16), one strobe cycle each, in the order the vertices
// are finished; the edge with last set ends the run and busy drops with it. The
// receiver cannot stall, so every strobe must be captured. For each edge the
// sequencer walks the vertices one per cycle, once to pick the next vertex and once
// to relax its row through the single read port of the weight memory. Entries never
// written since reset read as undefined.
`default_nettype none

module dense_shortest_path_tree (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [dspt_pkg::VBITS-1:0]          row,
	input  wire logic [dspt_pkg::VBITS-1:0]          col,
	input  wire logic [15:0]                         weight,
	input  wire logic                                start_req,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [dspt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [15:0]                         cfg_data,
	output logic                                     strobe,
	output logic      [dspt_pkg::NODE_BITS-1:0]      from_vertex,
	output logic      [dspt_pkg::NODE_BITS-1:0]      to_vertex,
	output logic      [dspt_pkg::LEN_BITS-1:0]       path_length,
	output logic                                     last
);

	localparam int VB = dspt_pkg::VBITS;
	localparam int NB = dspt_pkg::NODE_BITS;
	localparam int LB = dspt_pkg::LEN_BITS;
	localparam int CB = dspt_pkg::CNT_BITS;
	localparam int SB = dspt_pkg::SUM_BITS;
	localparam int WB = dspt_pkg::WEIGHT_BITS;
	localparam int NODES = dspt_pkg::MAX_NODES;

	dspt_pkg::step_t step_q;
	dspt_pkg::ucw_t  uc;

	logic [NB-1:0]                    node_count_q;
	logic [dspt_pkg::NE_BITS-1:0]     no_edge_q;

	logic [VB-1:0] v_q;
	logic [VB-1:0] round_q;
	logic [VB-1:0] u_q;
	logic [LB-1:0] u_len_q;

	logic [LB-1:0] best_q [NODES];
	logic [NB-1:0] pred_q [NODES];
	logic [NODES-1:0] fin_q;

	// running selection
	logic [LB-1:0] minv_q;
	logic          found_q;
	logic [VB-1:0] pick_q;
	logic [LB-1:0] pick_len_q;
	logic [NB-1:0] pick_pred_q;
	logic [VB-1:0] fb_q;
	logic [LB-1:0] fb_len_q;
	logic [NB-1:0] fb_pred_q;

	// memory read data stage
	logic          init_s1;
	logic          relax_s1;
	logic [VB-1:0] v_s1;

	logic          accept;
	logic          jump;
	logic [CB-1:0] n_eff;
	logic [CB-1:0] n_m1;
	logic [VB-1:0] n_last;
	logic          v_last;
	logic          last_round;

	logic          ram_we;
	logic [dspt_pkg::ADDR_BITS-1:0] ram_waddr;
	logic [dspt_pkg::ADDR_BITS-1:0] ram_raddr;
	logic [VB-1:0] rd_row;
	logic [WB-1:0] ram_rdata;

	logic [VB-1:0] bidx;
	logic [LB-1:0] best_rd;
	logic          fin_rd;
	logic [SB-1:0] relax_sum;
	logic [LB-1:0] relax_len;
	logic          relax_take;

	logic [VB-1:0] sel_v;
	logic [LB-1:0] sel_len;
	logic [NB-1:0] sel_pred;

	assign uc        = dspt_pkg::ucode(step_q);
	assign busy      = (step_q != dspt_pkg::STEP_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (node_count_q < NB'(2))
			n_eff = CB'(2);
		else if (node_count_q > NB'(NODES))
			n_eff = CB'(NODES);
		else
			n_eff = node_count_q[CB-1:0];
	end

	assign n_m1       = n_eff - CB'(1);
	assign n_last     = n_m1[VB-1:0];
	assign v_last     = (v_q == n_last);
	assign last_round = (round_q == n_last);

	always_comb begin
		case (uc.cond)
			dspt_pkg::COND_NEVER:   jump = 1'b0;
			dspt_pkg::COND_START:   jump = accept && start_req;
			dspt_pkg::COND_VLAST:   jump = v_last;
			dspt_pkg::COND_LASTRND: jump = last_round;
			default:                jump = 1'b0;
		endcase
	end

	// weight memory
	assign ram_we    = accept && ({1'b0, row} < CB'(NODES)) && ({1'b0, col} < CB'(NODES));
	assign ram_waddr = {row, col};
	assign rd_row    = uc.init_rd ? '0 : u_q;
	assign ram_raddr = {rd_row, v_q};

	dspt_ram #(
		.WIDTH(WB),
		.DEPTH(dspt_pkg::MAT_DEPTH)
	) u_wmem (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(WB'(weight)),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// one read port on best_q and fin_q: scan walks v_q, relax walks v_s1
	assign bidx    = relax_s1 ? v_s1 : v_q;
	assign best_rd = best_q[bidx];
	assign fin_rd  = fin_q[bidx];

	assign relax_sum  = SB'(u_len_q) + SB'(ram_rdata);
	assign relax_len  = dspt_pkg::sat_len(relax_sum);
	assign relax_take = relax_s1 && !fin_rd && (relax_len < best_rd);

	// no candidate at or under the limit: take the highest unfinished vertex
	assign sel_v    = found_q ? pick_q      : fb_q;
	assign sel_len  = found_q ? pick_len_q  : fb_len_q;
	assign sel_pred = found_q ? pick_pred_q : fb_pred_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= dspt_pkg::STEP_IDLE;
			node_count_q <= dspt_pkg::NODE_COUNT_RST;
			no_edge_q    <= dspt_pkg::NO_EDGE_RST;
			init_s1      <= 1'b0;
			relax_s1     <= 1'b0;
			strobe       <= 1'b0;
			fin_q        <= '0;
		end else begin
			step_q   <= jump ? uc.tgt : uc.nxt;
			init_s1  <= uc.init_rd;
			relax_s1 <= uc.relax_rd;
			strobe   <= uc.emit;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					dspt_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data[NB-1:0];
					dspt_pkg::CFG_NO_EDGE:    no_edge_q    <= cfg_data;
					default: ;
				endcase
			end
			if (uc.clr_run)
				fin_q <= '0;
			else if (uc.emit)
				fin_q[sel_v] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		v_s1 <= v_q;
		if (uc.v_one)
			v_q <= VB'(1);
		else if (uc.v_inc)
			v_q <= v_q + VB'(1);

		if (uc.clr_run)
			round_q <= VB'(1);
		else if (uc.emit)
			round_q <= round_q + VB'(1);

		if (uc.clr_run) begin
			for (int i = 0; i < NODES; i++)
				pred_q[i] <= NB'(1);
		end else if (relax_take) begin
			pred_q[v_s1] <= NB'(u_q) + NB'(1);
		end

		if (init_s1)
			best_q[v_s1] <= dspt_pkg::sat_len(SB'(ram_rdata));
		else if (relax_take)
			best_q[v_s1] <= relax_len;

		if (uc.scan_clr) begin
			minv_q  <= LB'(no_edge_q);
			found_q <= 1'b0;
		end else if (uc.scan_en && !fin_rd) begin
			fb_q      <= v_q;
			fb_len_q  <= best_rd;
			fb_pred_q <= pred_q[v_q];
			if (best_rd <= minv_q) begin
				minv_q      <= best_rd;
				found_q     <= 1'b1;
				pick_q      <= v_q;
				pick_len_q  <= best_rd;
				pick_pred_q <= pred_q[v_q];
			end
		end

		if (uc.emit) begin
			u_q         <= sel_v;
			u_len_q     <= sel_len;
			from_vertex <= sel_pred;
			to_vertex   <= NB'(sel_v) + NB'(1);
			path_length <= sel_len;
			last        <= last_round;
		end
	end

endmodule

`default_nettype wire

### rtl/core/dspt_chk.sv
`default_nettype none
`include "dense_shortest_path_tree_defines.svh"

module dspt_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire logic                           start_req,
	input wire logic                           strobe,
	input wire logic [dspt_pkg::NODE_BITS-1:0] from_vertex,
	input wire logic [dspt_pkg::NODE_BITS-1:0] to_vertex,
	input wire logic                           last
);

	// a run keeps busy up while edges are still to come
	`DSPT_ASSERT_NOW(a_mid_run_busy, strobe && !last, busy, "edge before last seen while idle")

	// a plain load transaction produces nothing
	`DSPT_ASSERT_NEXT(a_load_quiet, start && !busy && !start_req, !strobe, "result after load")

	// the source is never reached, and no edge is a self loop
	`DSPT_ASSERT_NOW(a_edge_shape, strobe,
		(to_vertex != from_vertex) && (to_vertex != 5'd1) && (to_vertex != 5'd0),
		"malformed tree edge")

	// the final edge closes the run; a new run may start on that same edge
	`DSPT_ASSERT_NEXT(a_last_ends, strobe && last, !strobe, "activity after last edge")

endmodule

bind dense_shortest_path_tree dspt_chk u_dspt_chk (.*);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int WATCHDOG_CYCLES = 5000;

	localparam int VB    = dspt_pkg::VBITS;
	localparam int NB    = dspt_pkg::NODE_BITS;
	localparam int LB    = dspt_pkg::LEN_BITS;
	localparam int IB    = dspt_pkg::CFG_IDX_BITS;
	localparam int NODES = dspt_pkg::MAX_NODES;

	typedef struct packed {
		logic [VB-1:0] r;
		logic [VB-1:0] c;
		logic [15:0]   w;
		logic          go;
	} entry_t;

	typedef struct packed {
		logic [NB-1:0] from_v;
		logic [NB-1:0] to_v;
		logic [LB-1:0] len;
		logic          is_last;
	} branch_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [VB-1:0] row = '0;
	logic [VB-1:0] col = '0;
	logic [15:0] weight = '0;
	logic start_req = 1'b0;
	logic cfg_valid = 1'b0;
	logic [IB-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic busy, cfg_ready, strobe, last;
	logic [NB-1:0] from_vertex, to_vertex;
	logic [LB-1:0] path_length;

	dense_shortest_path_tree dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.row         (row),
		.col         (col),
		.weight      (weight),
		.start_req   (start_req),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.strobe      (strobe),
		.from_vertex (from_vertex),
		.to_vertex   (to_vertex),
		.path_length (path_length),
		.last        (last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	entry_t  entry_q[$];
	branch_t branch_q[$];

	// predictor state, updated on accepted transactions only
	logic [15:0]                    adj [NODES][NODES];
	logic [NB-1:0]                  nodes_reg = dspt_pkg::NODE_COUNT_RST;
	logic [dspt_pkg::NE_BITS-1:0]   noedge_reg = dspt_pkg::NO_EDGE_RST;

	bit took = 1'b0;
	int quiet_cycles = 0;
	int mismatches = 0;

	function automatic int active_nodes(input logic [NB-1:0] cnt);
		if (cnt < 2)
			return 2;
		if (cnt > NODES)
			return NODES;
		return int'(cnt);
	endfunction

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// dense Dijkstra from vertex 1; queues one tree branch per finished vertex
	task automatic predict_tree();
		int n, v, rnd, pick, fallback;
		bit found;
		bit done [NODES];
		logic [LB-1:0] reach [NODES];
		logic [NB-1:0] via [NODES];
		logic [LB-1:0] minv;
		logic [LB:0] s;
		branch_t b;
		n = active_nodes(nodes_reg);
		for (v = 0; v < NODES; v++) begin
			done[v] = 1'b0;
			via[v] = 5'd1;
			reach[v] = '0;
		end
		for (v = 1; v < n; v++)
			reach[v] = LB'(adj[0][v]);
		for (rnd = 1; rnd < n; rnd++) begin
			minv = LB'(noedge_reg);
			pick = 0;
			fallback = 0;
			found = 1'b0;
			// ties go to the highest index
			for (v = 1; v < n; v++) begin
				if (!done[v]) begin
					fallback = v;
					if (reach[v] <= minv) begin
						minv = reach[v];
						pick = v;
						found = 1'b1;
					end
				end
			end
			if (!found)
				pick = fallback;
			b.from_v = via[pick];
			b.to_v = NB'(pick + 1);
			b.len = reach[pick];
			b.is_last = (rnd == n - 1);
			branch_q.push_back(b);
			done[pick] = 1'b1;
			for (v = 1; v < n; v++) begin
				if (!done[v]) begin
					s = {1'b0, reach[pick]} + (LB + 1)'(adj[pick][v]);
					if (s > {1'b0, {LB{1'b1}}})
						s = {1'b0, {LB{1'b1}}};
					if (s[LB-1:0] < reach[v]) begin
						reach[v] = s[LB-1:0];
						via[v] = NB'(pick + 1);
					end
				end
			end
		end
	endtask

	// monitor: samples every transaction at the rising edge
	always @(posedge clk) begin
		branch_t want;
		branch_t got;
		if (arst_n) begin
			took = start && !busy;
			quiet_cycles++;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == dspt_pkg::CFG_NODE_COUNT)
					nodes_reg = cfg_data[NB-1:0];
				else
					noedge_reg = cfg_data;
				quiet_cycles = 0;
			end
			if (took) begin
				adj[row][col] = weight;
				if (start_req)
					predict_tree();
				quiet_cycles = 0;
			end
			if (strobe) begin
				got.from_v = from_vertex;
				got.to_v = to_vertex;
				got.len = path_length;
				got.is_last = last;
				if (branch_q.size() == 0) begin
					log_mismatch($sformatf("unexpected branch %0d->%0d len %0d last %0d",
						got.from_v, got.to_v, got.len, got.is_last));
				end else begin
					want = branch_q.pop_front();
					if (got !== want)
						log_mismatch($sformatf(
							"branch mismatch: exp %0d->%0d len %0d last %0d, got %0d->%0d len %0d last %0d",
							want.from_v, want.to_v, want.len, want.is_last,
							got.from_v, got.to_v, got.len, got.is_last));
				end
				quiet_cycles = 0;
			end
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// driver: bursts of entries with random gaps between them
	int burst_left = 1;
	int gap_left = 0;
	entry_t nx;

	always @(negedge clk) begin
		if (arst_n && !(start && !took)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (entry_q.size() != 0) begin
				nx = entry_q.pop_front();
				start <= 1'b1;
				row <= nx.r;
				col <= nx.c;
				weight <= nx.w;
				start_req <= nx.go;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// stimulus side bookkeeping
	bit filled [NODES][NODES];
	int cur_n = 5;
	logic [15:0] cur_none = dspt_pkg::NO_EDGE_RST;
	int items_queued = 0;

	task automatic queue_entry(input int r, input int c, input logic [15:0] w, input bit go);
		entry_t e;
		e.r = VB'(r);
		e.c = VB'(c);
		e.w = w;
		e.go = go;
		entry_q.push_back(e);
		filled[r][c] = 1'b1;
		items_queued++;
	endtask

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 9))
			0, 1: return cur_none;
			2: return 16'd0;
			3: return 16'hFFFF;
			4, 5: return 16'($urandom_range(0, 3));
			6, 7: return 16'($urandom_range(0, 300));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_vertex();
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, NODES - 1);
		return $urandom_range(0, cur_n - 1);
	endfunction

	task automatic queue_extras(input int k);
		int i;
		for (i = 0; i < k; i++)
			queue_entry(pick_vertex(), pick_vertex(), pick_weight(), 1'b0);
	endtask

	// a run may only read entries that were written since reset
	task automatic queue_run();
		int r, c;
		for (r = 0; r < cur_n; r++)
			for (c = 0; c < cur_n; c++)
				if (!filled[r][c])
					queue_entry(r, c, pick_weight(), 1'b0);
		queue_entry(pick_vertex(), pick_vertex(), pick_weight(), 1'b1);
	endtask

	// checked at the rising edge, where the queue and start are settled
	task automatic wait_quiet();
		do
			@(posedge clk);
		while (entry_q.size() != 0 || start || branch_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IB-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [NB-1:0] nodes, input logic [15:0] none);
		logic [10:0] upper;
		upper = ($urandom_range(0, 1) == 0) ? 11'd0 : 11'($urandom);
		write_reg(dspt_pkg::CFG_NODE_COUNT, {upper, nodes});
		write_reg(dspt_pkg::CFG_NO_EDGE, none);
		cur_n = active_nodes(nodes);
		cur_none = none;
	endtask

	task automatic run_phase(input logic [NB-1:0] nodes, input logic [15:0] none,
			input int runs, input int max_extra);
		int i;
		wait_quiet();
		set_config(nodes, none);
		for (i = 0; i < runs; i++) begin
			queue_extras($urandom_range(0, max_extra));
			queue_run();
		end
	endtask

	initial begin
		int r, c, k;
		logic [15:0] w;
		logic [15:0] row0 [5];
		logic [NB-1:0] nsel;
		logic [15:0] esel;
		row0 = '{16'd0, 16'd999, 16'd3, 16'd3, 16'hFFFF};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: five vertices, a missing edge at 999, a tie from the source,
		// zero and full-scale weights; the last entry starts the run
		for (r = 0; r < 5; r++)
			for (c = 0; c < 5; c++) begin
				if (r == 0)
					w = row0[c];
				else if (r == 3 && c == 1)
					w = 16'hFFFF;
				else
					w = ((r + c) % 3 == 0) ? 16'd999 : 16'((r * c) % 4);
				queue_entry(r, c, w, (r == 4 && c == 4));
			end

		run_phase(5'd0, 16'hFFFF, 3, 4);     // below range acts as two vertices
		run_phase(5'd1, 16'd0, 2, 3);
		run_phase(5'd4, 16'd0, 3, 6);        // zero limit: only zero-length paths qualify, else highest unfinished wins
		run_phase(5'd16, 16'd999, 3, 8);
		run_phase(5'd31, 16'hFFFF, 2, 10);   // above range acts as the maximum
		run_phase(5'd3, 16'd1, 3, 6);

		while (items_queued < 420) begin
			case ($urandom_range(0, 15))
				0: nsel = 5'd16;
				1: nsel = 5'($urandom_range(17, 31));
				2: nsel = 5'($urandom_range(0, 1));
				default: nsel = 5'($urandom_range(2, 8));
			endcase
			case ($urandom_range(0, 7))
				0: esel = 16'd0;
				1: esel = 16'hFFFF;
				2: esel = 16'd999;
				3: esel = 16'($urandom_range(0, 10));
				default: esel = 16'($urandom);
			endcase
			k = (active_nodes(nsel) > 8) ? 2 : $urandom_range(2, 5);
			run_phase(nsel, esel, k, 10);
		end

		wait_quiet();
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### dense_shortest_path_tree.f
+incdir+rtl/core
rtl/core/dspt_pkg.sv
rtl/core/dspt_ram.sv
rtl/core/dense_shortest_path_tree.sv
rtl/core/dspt_chk.sv
bench/tb_top.sv
